// ===== rtl/mfa_pkg.sv =====
package mfa_pkg;

	localparam int VALUE_BITS = 16;
	localparam int SUM_WHOLE_W = 18;
	localparam int SUM_WORD_W  = 32;
	localparam int PROD_W     = 2 * VALUE_BITS;
	localparam int NUM_W      = 2 * VALUE_BITS + 1;
	localparam int WHOLE_W    = SUM_WHOLE_W;
	localparam int K_W        = $clog2(NUM_W + 1);
	localparam int CNT_W      = $clog2(NUM_W);

	typedef enum logic [1:0] {
		MUL_A1D2,
		MUL_A2D1,
		MUL_D1D2
	} mul_sel_t;

	typedef enum logic [1:0] {
		DIV_NUM_G,
		DIV_DEN_G,
		DIV_NUM_DEN
	} div_sel_t;

	typedef struct packed {
		logic      load;
		logic      mul_first;
		logic      mul_acc;
		logic      mul_den;
		mul_sel_t  mul_sel;
		logic      den_one;
		logic      gcd_init;
		logic      gcd_step;
		logic      gcd_shift;
		logic      div_start;
		logic      div_step;
		logic      div_wb;
		div_sel_t  div_sel;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic num_zero;
		logic gcd_eq;
		logic k_zero;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/mfa_ctrl.sv =====
module mfa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  mfa_pkg::sts_t sts,
	output mfa_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_C,
		ST_CHECK,
		ST_GCD,
		ST_GSHIFT,
		ST_DIV_LOAD,
		ST_DIV_RUN,
		ST_DIV_WB,
		ST_FIN
	} state_t;

	state_t                   state_q, state_d;
	logic [mfa_pkg::CNT_W-1:0] cnt_q;
	mfa_pkg::div_sel_t         div_sel_q, div_sel_d;

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = mfa_pkg::MUL_A1D2;
		cmd.div_sel = div_sel_q;
		state_d     = state_q;
		div_sel_d   = div_sel_q;
		in_stall    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				if (sts.bad) begin
					state_d = ST_FIN;
				end else begin
					cmd.mul_first = 1'b1;
					cmd.mul_sel   = mfa_pkg::MUL_A1D2;
					state_d       = ST_MUL_B;
				end
			end
			ST_MUL_B: begin
				cmd.mul_acc = 1'b1;
				cmd.mul_sel = mfa_pkg::MUL_A2D1;
				state_d     = ST_MUL_C;
			end
			ST_MUL_C: begin
				cmd.mul_den = 1'b1;
				cmd.mul_sel = mfa_pkg::MUL_D1D2;
				state_d     = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.num_zero) begin
					cmd.den_one = 1'b1;
					state_d     = ST_FIN;
				end else begin
					cmd.gcd_init = 1'b1;
					state_d      = ST_GCD;
				end
			end
			ST_GCD: begin
				if (sts.gcd_eq) begin
					state_d = ST_GSHIFT;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_GSHIFT: begin
				if (sts.k_zero) begin
					div_sel_d = mfa_pkg::DIV_NUM_G;
					state_d   = ST_DIV_LOAD;
				end else begin
					cmd.gcd_shift = 1'b1;
				end
			end
			ST_DIV_LOAD: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				cmd.div_step = 1'b1;
				if (cnt_q == mfa_pkg::CNT_W'(mfa_pkg::NUM_W - 1)) begin
					state_d = ST_DIV_WB;
				end
			end
			ST_DIV_WB: begin
				cmd.div_wb = 1'b1;
				unique case (div_sel_q)
					mfa_pkg::DIV_NUM_G: begin
						div_sel_d = mfa_pkg::DIV_DEN_G;
						state_d   = ST_DIV_LOAD;
					end
					mfa_pkg::DIV_DEN_G: begin
						div_sel_d = mfa_pkg::DIV_NUM_DEN;
						state_d   = ST_DIV_LOAD;
					end
					default: begin
						state_d = ST_FIN;
					end
				endcase
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			div_sel_q <= mfa_pkg::DIV_NUM_G;
		end else begin
			state_q   <= state_d;
			div_sel_q <= div_sel_d;
			if (state_q == ST_DIV_LOAD) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/mfa_dp.sv =====
module mfa_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mfa_pkg::cmd_t                      cmd,
	output mfa_pkg::sts_t                      sts,
	input  logic [mfa_pkg::VALUE_BITS-1:0]     first_whole,
	input  logic [mfa_pkg::VALUE_BITS-1:0]     first_numerator,
	input  logic [mfa_pkg::VALUE_BITS-1:0]     first_denominator,
	input  logic [mfa_pkg::VALUE_BITS-1:0]     second_whole,
	input  logic [mfa_pkg::VALUE_BITS-1:0]     second_numerator,
	input  logic [mfa_pkg::VALUE_BITS-1:0]     second_denominator,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [mfa_pkg::SUM_WHOLE_W-1:0]    sum_whole,
	output logic [mfa_pkg::SUM_WORD_W-1:0]     sum_numerator,
	output logic [mfa_pkg::SUM_WORD_W-1:0]     sum_denominator,
	output logic                               bad_denominator
);

	localparam int VB = mfa_pkg::VALUE_BITS;
	localparam int NW = mfa_pkg::NUM_W;

	logic [VB-1:0]                    a1_q, d1_q, a2_q, d2_q;
	logic                             bad_q;
	logic [mfa_pkg::WHOLE_W-1:0]      whole_q;
	logic [NW-1:0]                    num_q, den_q;
	logic [NW-1:0]                    gx_q, gy_q;
	logic [mfa_pkg::K_W-1:0]          gk_q;
	logic [NW-1:0]                    dvd_q, dsr_q, rem_q;

	logic [VB-1:0]                    mul_a, mul_b;
	logic [mfa_pkg::PROD_W-1:0]       prod;
	logic [NW:0]                      rem_sh, rem_diff;
	logic                             rem_ge;

	logic                             out_valid_q;
	logic [mfa_pkg::SUM_WHOLE_W-1:0]  sum_whole_q;
	logic [mfa_pkg::SUM_WORD_W-1:0]   sum_numerator_q, sum_denominator_q;
	logic                             bad_out_q;

	always_comb begin
		case (cmd.mul_sel)
			mfa_pkg::MUL_A1D2: begin
				mul_a = a1_q;
				mul_b = d2_q;
			end
			mfa_pkg::MUL_A2D1: begin
				mul_a = a2_q;
				mul_b = d1_q;
			end
			default: begin
				mul_a = d1_q;
				mul_b = d2_q;
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign rem_sh   = {rem_q, dvd_q[NW-1]};
	assign rem_ge   = (rem_sh >= {1'b0, dsr_q});
	assign rem_diff = rem_sh - {1'b0, dsr_q};

	assign sts.bad      = bad_q;
	assign sts.num_zero = (num_q == '0);
	assign sts.gcd_eq   = (gx_q == gy_q);
	assign sts.k_zero   = (gk_q == '0);
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a1_q    <= first_numerator;
			d1_q    <= first_denominator;
			a2_q    <= second_numerator;
			d2_q    <= second_denominator;
			bad_q   <= (first_denominator == '0) || (second_denominator == '0);
			whole_q <= mfa_pkg::WHOLE_W'(first_whole) + mfa_pkg::WHOLE_W'(second_whole);
		end
		if (cmd.mul_first) begin
			num_q <= NW'(prod);
		end
		if (cmd.mul_acc) begin
			num_q <= num_q + NW'(prod);
		end
		if (cmd.mul_den) begin
			den_q <= NW'(prod);
		end
		if (cmd.den_one) begin
			den_q <= NW'(1);
		end
		if (cmd.gcd_init) begin
			gx_q <= num_q;
			gy_q <= den_q;
			gk_q <= '0;
		end
		if (cmd.gcd_step) begin
			case ({gx_q[0], gy_q[0]})
				2'b00: begin
					gx_q <= gx_q >> 1;
					gy_q <= gy_q >> 1;
					gk_q <= gk_q + 1'b1;
				end
				2'b01: begin
					gx_q <= gx_q >> 1;
				end
				2'b10: begin
					gy_q <= gy_q >> 1;
				end
				default: begin
					if (gx_q > gy_q) begin
						gx_q <= (gx_q - gy_q) >> 1;
					end else begin
						gy_q <= (gy_q - gx_q) >> 1;
					end
				end
			endcase
		end
		if (cmd.gcd_shift) begin
			gx_q <= gx_q << 1;
			gk_q <= gk_q - 1'b1;
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			case (cmd.div_sel)
				mfa_pkg::DIV_NUM_G: begin
					dvd_q <= num_q;
					dsr_q <= gx_q;
				end
				mfa_pkg::DIV_DEN_G: begin
					dvd_q <= den_q;
					dsr_q <= gx_q;
				end
				default: begin
					dvd_q <= num_q;
					dsr_q <= den_q;
				end
			endcase
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_diff[NW-1:0] : rem_sh[NW-1:0];
			dvd_q <= {dvd_q[NW-2:0], rem_ge};
		end
		if (cmd.div_wb) begin
			case (cmd.div_sel)
				mfa_pkg::DIV_NUM_G: begin
					num_q <= dvd_q;
				end
				mfa_pkg::DIV_DEN_G: begin
					den_q <= dvd_q;
				end
				default: begin
					whole_q <= whole_q + mfa_pkg::WHOLE_W'(dvd_q);
					num_q   <= rem_q;
				end
			endcase
		end
		if (cmd.out_load) begin
			if (bad_q) begin
				sum_whole_q       <= '0;
				sum_numerator_q   <= '0;
				sum_denominator_q <= '0;
				bad_out_q         <= 1'b1;
			end else begin
				sum_whole_q       <= mfa_pkg::SUM_WHOLE_W'(whole_q);
				sum_numerator_q   <= mfa_pkg::SUM_WORD_W'(num_q);
				sum_denominator_q <= mfa_pkg::SUM_WORD_W'(den_q);
				bad_out_q         <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign sum_whole       = sum_whole_q;
	assign sum_numerator   = sum_numerator_q;
	assign sum_denominator = sum_denominator_q;
	assign bad_denominator = bad_out_q;

`ifndef SYNTH
	a_gcd_step_unequal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gcd_step |-> (gx_q != gy_q))
		else $error("gcd step issued on equal operands");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (dsr_q != '0))
		else $error("divider started with zero divisor");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("pending result overwritten");

	a_proper_fraction: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && !bad_q) |-> (num_q < den_q))
		else $error("result fraction not proper");
`endif

endmodule

// ===== rtl/mixed_fraction_adder_unit.sv =====
// Adds two unsigned mixed numbers (whole, numerator, denominator) and returns the
// sum as whole part plus a reduced proper fraction; a zero fraction is 0/1, and a
// zero input denominator gives bad_denominator with all other fields zero. One
// transaction is worked at a time: the cross products are formed on one shared
// multiplier, the reduction runs a binary GCD of one subtract-or-shift per
// cycle (at most 2*(2*VALUE_BITS+1) steps, then one shift back per common factor
// of two), and one restoring divider producing a quotient bit per cycle does the
// three divisions. A zero denominator skips straight to the result, and a zero
// fraction sum skips the reduction and the divisions. The result sits in an output
// register, so a finished result may wait on out_stall while the next item is
// accepted and worked.
module mixed_fraction_adder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mfa_pkg::VALUE_BITS-1:0]  first_whole,
	input  logic [mfa_pkg::VALUE_BITS-1:0]  first_numerator,
	input  logic [mfa_pkg::VALUE_BITS-1:0]  first_denominator,
	input  logic [mfa_pkg::VALUE_BITS-1:0]  second_whole,
	input  logic [mfa_pkg::VALUE_BITS-1:0]  second_numerator,
	input  logic [mfa_pkg::VALUE_BITS-1:0]  second_denominator,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mfa_pkg::SUM_WHOLE_W-1:0] sum_whole,
	output logic [mfa_pkg::SUM_WORD_W-1:0]  sum_numerator,
	output logic [mfa_pkg::SUM_WORD_W-1:0]  sum_denominator,
	output logic                            bad_denominator
);

	mfa_pkg::cmd_t cmd;
	mfa_pkg::sts_t sts;

	mfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mfa_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.first_whole        (first_whole),
		.first_numerator    (first_numerator),
		.first_denominator  (first_denominator),
		.second_whole       (second_whole),
		.second_numerator   (second_numerator),
		.second_denominator (second_denominator),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.sum_whole          (sum_whole),
		.sum_numerator      (sum_numerator),
		.sum_denominator    (sum_denominator),
		.bad_denominator    (bad_denominator)
	);

endmodule

// ===== tb/tb_mixed_fraction_adder_unit.sv =====
module tb_mixed_fraction_adder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1300;
	localparam int QUIET_FIRST  = 500;
	localparam int QUIET_LAST   = 699;
	localparam int DRAIN_CYCLES = 300;

	typedef logic [mfa_pkg::VALUE_BITS-1:0] mfa_value_t;

	typedef struct packed {
		mfa_value_t first_whole;
		mfa_value_t first_numerator;
		mfa_value_t first_denominator;
		mfa_value_t second_whole;
		mfa_value_t second_numerator;
		mfa_value_t second_denominator;
	} mfa_operands_t;

	typedef struct packed {
		logic [mfa_pkg::SUM_WHOLE_W-1:0] whole;
		logic [mfa_pkg::SUM_WORD_W-1:0]  numerator;
		logic [mfa_pkg::SUM_WORD_W-1:0]  denominator;
		logic                            bad;
	} mfa_sum_t;

	typedef struct packed {
		mfa_operands_t ops;
		logic          known;
		mfa_sum_t      sum;
	} mfa_case_t;

	localparam mfa_sum_t NO_SUM  = '0;
	localparam mfa_sum_t BAD_SUM = '{0, 0, 0, 1};
	localparam int N_DIRECTED = 22;

	// known rows: zero denominators, zero fractions, extremes, simple reductions
	localparam mfa_case_t DIRECTED [N_DIRECTED] = '{
		'{'{5, 3, 0, 7, 1, 4}, 1'b1, BAD_SUM},
		'{'{5, 3, 4, 7, 1, 0}, 1'b1, BAD_SUM},
		'{'{'1, '1, 0, '1, '1, 0}, 1'b1, BAD_SUM},
		'{'{0, 0, 1, 0, 0, 1}, 1'b1, '{0, 0, 1, 0}},
		'{'{'1, 0, '1, '1, 0, '1}, 1'b1, '{131070, 0, 1, 0}},
		'{'{'1, '1, '1, '1, '1, '1}, 1'b1, '{131072, 0, 1, 0}},
		'{'{0, 1, 2, 0, 1, 2}, 1'b1, '{1, 0, 1, 0}},
		'{'{0, 1, 3, 0, 1, 3}, 1'b1, '{0, 2, 3, 0}},
		'{'{0, 7, 2, 0, 0, 1}, 1'b1, '{3, 1, 2, 0}},
		'{'{0, 1, 32768, 0, 1, 32768}, 1'b1, '{0, 1, 16384, 0}},
		'{'{'1, '1, 1, '1, '1, 1}, 1'b1, '{262140, 0, 1, 0}},
		'{'{3, 0, 5, 4, 2, 5}, 1'b1, '{7, 2, 5, 0}},
		'{'{0, 3, 4, 0, 3, 4}, 1'b1, '{1, 1, 2, 0}},
		'{'{0, 0, '1, 0, 0, 1}, 1'b1, '{0, 0, 1, 0}},
		'{'{12, 5, 6, 30, 7, 10}, 1'b0, NO_SUM},
		'{'{0, 65534, 65535, 0, 65533, 65521}, 1'b0, NO_SUM},
		'{'{0, 1, 1, 0, 0, 65535}, 1'b0, NO_SUM},
		'{'{0, 65535, 3, 0, 65535, 7}, 1'b0, NO_SUM},
		'{'{0, 1, 65535, 0, 1, 65534}, 1'b0, NO_SUM},
		'{'{0, 65534, 65535, 0, 65534, 65535}, 1'b0, NO_SUM},
		'{'{0, 1, 6, 0, 1, 10}, 1'b0, NO_SUM},
		'{'{100, 12345, 54321, 200, 22222, 33333}, 1'b0, NO_SUM}
	};

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	mfa_value_t                      first_whole;
	mfa_value_t                      first_numerator;
	mfa_value_t                      first_denominator;
	mfa_value_t                      second_whole;
	mfa_value_t                      second_numerator;
	mfa_value_t                      second_denominator;
	logic                            out_valid;
	logic                            out_stall;
	logic [mfa_pkg::SUM_WHOLE_W-1:0] sum_whole;
	logic [mfa_pkg::SUM_WORD_W-1:0]  sum_numerator;
	logic [mfa_pkg::SUM_WORD_W-1:0]  sum_denominator;
	logic                            bad_denominator;

	mfa_sum_t pending_sums [$];
	int       errors = 0;
	bit       quiet  = 1'b0;

	mixed_fraction_adder_unit dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.first_whole        (first_whole),
		.first_numerator    (first_numerator),
		.first_denominator  (first_denominator),
		.second_whole       (second_whole),
		.second_numerator   (second_numerator),
		.second_denominator (second_denominator),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.sum_whole          (sum_whole),
		.sum_numerator      (sum_numerator),
		.sum_denominator    (sum_denominator),
		.bad_denominator    (bad_denominator)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic mfa_sum_t reduced_sum(mfa_operands_t ops);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] whole;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] t;
		mfa_sum_t    s;
		s = '0;
		if (ops.first_denominator == 0 || ops.second_denominator == 0) begin
			s.bad = 1'b1;
			return s;
		end
		num = 64'(ops.first_numerator) * 64'(ops.second_denominator)
			+ 64'(ops.second_numerator) * 64'(ops.first_denominator);
		den = 64'(ops.first_denominator) * 64'(ops.second_denominator);
		whole = 64'(ops.first_whole) + 64'(ops.second_whole);
		if (num != 0) begin
			x = num;
			y = den;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			num = num / x;
			den = den / x;
		end else begin
			den = 1;
		end
		whole = whole + num / den;
		num = num % den;
		s.whole = whole[mfa_pkg::SUM_WHOLE_W-1:0];
		s.numerator = num[mfa_pkg::SUM_WORD_W-1:0];
		s.denominator = den[mfa_pkg::SUM_WORD_W-1:0];
		return s;
	endfunction

	// mix of zero, max, tiny, powers of two, short random and full random values
	function automatic mfa_value_t random_value();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return mfa_value_t'($urandom_range(15));
			3: return mfa_value_t'(1) << $urandom_range(mfa_pkg::VALUE_BITS - 1);
			4, 5: return r[mfa_pkg::VALUE_BITS-1:0] >> $urandom_range(mfa_pkg::VALUE_BITS - 1);
			default: return r[mfa_pkg::VALUE_BITS-1:0];
		endcase
	endfunction

	function automatic mfa_value_t random_denominator();
		mfa_value_t v;
		if ($urandom_range(99) < 4)
			return '0;
		v = random_value();
		while (v == 0)
			v = random_value();
		return v;
	endfunction

	function automatic mfa_operands_t random_operands();
		mfa_operands_t ops;
		ops.first_whole = random_value();
		ops.first_numerator = random_value();
		ops.first_denominator = random_denominator();
		ops.second_whole = random_value();
		ops.second_numerator = random_value();
		ops.second_denominator = random_denominator();
		if ($urandom_range(9) == 0)
			ops.second_denominator = ops.first_denominator;
		return ops;
	endfunction

	task automatic offer_operands(input mfa_operands_t ops, input mfa_sum_t want);
		while (!quiet && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		first_whole <= ops.first_whole;
		first_numerator <= ops.first_numerator;
		first_denominator <= ops.first_denominator;
		second_whole <= ops.second_whole;
		second_numerator <= ops.second_numerator;
		second_denominator <= ops.second_denominator;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_sums.push_back(want);
	endtask

	always @(posedge clk)
		out_stall <= !quiet && ($urandom_range(99) < 8);

	always @(posedge clk) begin
		mfa_sum_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sums.size() == 0) begin
				$display("%0t: unexpected transaction whole=%0d num=%0d den=%0d bad=%0b",
					$time, sum_whole, sum_numerator, sum_denominator, bad_denominator);
				errors++;
			end else begin
				want = pending_sums.pop_front();
				if (sum_whole !== want.whole) begin
					$display("%0t: sum_whole expected %0d actual %0d",
						$time, want.whole, sum_whole);
					errors++;
				end
				if (sum_numerator !== want.numerator) begin
					$display("%0t: sum_numerator expected %0d actual %0d",
						$time, want.numerator, sum_numerator);
					errors++;
				end
				if (sum_denominator !== want.denominator) begin
					$display("%0t: sum_denominator expected %0d actual %0d",
						$time, want.denominator, sum_denominator);
					errors++;
				end
				if (bad_denominator !== want.bad) begin
					$display("%0t: bad_denominator expected %0b actual %0b",
						$time, want.bad, bad_denominator);
					errors++;
				end
			end
		end
	end

	initial begin
		mfa_operands_t ops;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		out_stall <= 1'b0;
		first_whole <= '0;
		first_numerator <= '0;
		first_denominator <= '0;
		second_whole <= '0;
		second_numerator <= '0;
		second_denominator <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].known)
				offer_operands(DIRECTED[i].ops, DIRECTED[i].sum);
			else
				offer_operands(DIRECTED[i].ops, reduced_sum(DIRECTED[i].ops));
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= QUIET_FIRST && i <= QUIET_LAST);
			ops = random_operands();
			offer_operands(ops, reduced_sum(ops));
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_sums.size() != 0)
			errors++;
		if (errors == 0)
			$display("tb_mixed_fraction_adder_unit: done, clean");
		else
			$display("tb_mixed_fraction_adder_unit: done, errors");
		$finish;
	end

	initial begin
		#10ms;
		$display("tb_mixed_fraction_adder_unit: done, errors");
		$finish;
	end

endmodule
